### rtl/core/tpc_pkg.sv
`timescale 1ns / 1ps
package tpc_pkg;

    localparam int NumAttr  = 9;
    localparam int NumEmit  = 6;
    localparam int TBits    = 30;
    localparam int DivSteps = 31;
    localparam int JobDepth = 2;

    localparam logic [2:0] PAT_V0_IN = 3'b100;
    localparam logic [2:0] PAT_V1_IN = 3'b010;
    localparam logic [2:0] PAT_V2_IN = 3'b001;

    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam logic [3:0] ATTR_W    = 4'd3;

    localparam logic REG_AXIS = 1'b0;
    localparam logic REG_POS  = 1'b1;

    typedef logic [8:0][31:0] t_vec;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [31:0] col_r;
        logic signed [31:0] col_g;
        logic signed [31:0] col_b;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic signed [31:0] out_r;
        logic signed [31:0] out_g;
        logic signed [31:0] out_b;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic               run_last;
    } t_out_word;

    typedef enum logic [2:0] {
        SRC_V0,
        SRC_V1,
        SRC_V2,
        SRC_C0,
        SRC_C1
    } t_src;

    typedef struct packed {
        logic [1:0]       axis;
        logic             pos;
        logic             do_cut;
        logic [2:0]       n_emit;
        logic [5:0][2:0]  src;
        logic [1:0][1:0]  cut_in;
        logic [1:0][1:0]  cut_out;
        logic [2:0][8:0][31:0] vtx;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_SETUP,
        B_PRE1,
        B_PRE2,
        B_DIV,
        B_ROUND,
        B_MUL,
        B_ACC,
        B_WFIX,
        B_EMIT
    } t_back_state;

    function automatic t_vec to_vec(t_in_word w);
        t_vec v;
        v[0] = w.pos_x;
        v[1] = w.pos_y;
        v[2] = w.pos_z;
        v[3] = w.pos_w;
        v[4] = w.col_r;
        v[5] = w.col_g;
        v[6] = w.col_b;
        v[7] = w.tex_u;
        v[8] = w.tex_v;
        return v;
    endfunction

    function automatic t_out_word to_out(t_vec v, logic last);
        t_out_word w;
        w.out_x    = v[0];
        w.out_y    = v[1];
        w.out_z    = v[2];
        w.out_w    = v[3];
        w.out_r    = v[4];
        w.out_g    = v[5];
        w.out_b    = v[6];
        w.out_u    = v[7];
        w.out_v    = v[8];
        w.run_last = last;
        return w;
    endfunction

endpackage

### rtl/core/triangle_plane_clipper.sv
// Flow: a clipped triangle takes two cuts (each a 31-step divider and 8 mul/add
//   pairs) before its words are emitted; an unclipped triangle is emitted directly.
// Vertices are taken one per cycle while the job queue has room; the back end
//   works on one triangle at a time and retires it with its last output word.
// Reset (synchronous, active low): vertex count, job queue and output valid flag
//   cleared, r_axis = 0, r_pos = 1.
`timescale 1ns / 1ps
module triangle_plane_clipper #(
    parameter int JOB_DEPTH = tpc_pkg::JobDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tpc_pkg::t_in_word  i_vtx,
    output logic               empty,
    input  logic               pop,
    output tpc_pkg::t_out_word o_vtx,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0]    r_axis;
    logic          r_pos;
    logic          w_job_push;
    logic          w_job_full;
    logic          w_job_valid;
    logic          w_job_pop;
    tpc_pkg::t_job w_job_in;
    tpc_pkg::t_job w_job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tpc_pkg::REG_POS) ? {31'd0, r_pos} : {30'd0, r_axis};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= 2'd0;
            r_pos  <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                tpc_pkg::REG_AXIS: r_axis <= pwdata[1:0];
                tpc_pkg::REG_POS:  r_pos  <= pwdata[0];
                default:           r_pos  <= r_pos;
            endcase
        end
    end

    tpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_vtx      (i_vtx),
        .i_axis     (r_axis),
        .i_pos      (r_pos),
        .o_job_push (w_job_push),
        .o_job      (w_job_in),
        .i_job_full (w_job_full)
    );

    tpc_job_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job_out)
    );

    tpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_vtx       (o_vtx)
    );

endmodule

### rtl/core/tpc_front.sv
`timescale 1ns / 1ps
module tpc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  tpc_pkg::t_in_word i_vtx,
    input  logic [1:0]        i_axis,
    input  logic              i_pos,
    output logic              o_job_push,
    output tpc_pkg::t_job     o_job,
    input  logic              i_job_full
);

    logic [1:0]    r_slot;
    tpc_pkg::t_vec r_v0;
    tpc_pkg::t_vec r_v1;
    tpc_pkg::t_vec w_v2;
    logic          w_accept;
    logic [2:0]    w_pat;

    function automatic logic is_out(tpc_pkg::t_vec v, logic [1:0] axis, logic pos);
        logic signed [32:0] c;
        logic signed [32:0] w;
        logic               res;
        c = $signed({v[{2'b00, axis}][31], v[{2'b00, axis}]});
        w = $signed({v[tpc_pkg::ATTR_W][31], v[tpc_pkg::ATTR_W]});
        if (axis == tpc_pkg::AXIS_NONE) begin
            res = 1'b0;
        end else if (pos) begin
            res = c > w;
        end else begin
            res = c < -w;
        end
        return res;
    endfunction

    assign w_v2     = tpc_pkg::to_vec(i_vtx);
    assign o_full   = (r_slot == 2'd2) && i_job_full;
    assign w_accept = i_push && !o_full;

    assign w_pat = (is_out(r_v0, i_axis, i_pos) ? 3'b000 : tpc_pkg::PAT_V0_IN)
                 | (is_out(r_v1, i_axis, i_pos) ? 3'b000 : tpc_pkg::PAT_V1_IN)
                 | (is_out(w_v2, i_axis, i_pos) ? 3'b000 : tpc_pkg::PAT_V2_IN);

    always_comb begin
        o_job.axis       = i_axis;
        o_job.pos        = i_pos;
        o_job.vtx[0]     = r_v0;
        o_job.vtx[1]     = r_v1;
        o_job.vtx[2]     = w_v2;
        o_job.do_cut     = 1'b1;
        o_job.n_emit     = 3'd3;
        o_job.src        = '0;
        o_job.cut_in     = '0;
        o_job.cut_out    = '0;
        case (w_pat)
            (tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V1_IN | tpc_pkg::PAT_V2_IN): begin
                o_job.do_cut = 1'b0;
                o_job.src[0] = tpc_pkg::SRC_V0;
                o_job.src[1] = tpc_pkg::SRC_V1;
                o_job.src[2] = tpc_pkg::SRC_V2;
            end
            (tpc_pkg::PAT_V1_IN | tpc_pkg::PAT_V2_IN): begin
                o_job.n_emit     = 3'd6;
                o_job.cut_in[0]  = 2'd2;
                o_job.cut_out[0] = 2'd0;
                o_job.cut_in[1]  = 2'd1;
                o_job.cut_out[1] = 2'd0;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V1;
                o_job.src[3] = tpc_pkg::SRC_V1;
                o_job.src[4] = tpc_pkg::SRC_V2;
                o_job.src[5] = tpc_pkg::SRC_C0;
            end
            (tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V2_IN): begin
                o_job.n_emit     = 3'd6;
                o_job.cut_in[0]  = 2'd0;
                o_job.cut_out[0] = 2'd1;
                o_job.cut_in[1]  = 2'd2;
                o_job.cut_out[1] = 2'd1;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V2;
                o_job.src[3] = tpc_pkg::SRC_V2;
                o_job.src[4] = tpc_pkg::SRC_V0;
                o_job.src[5] = tpc_pkg::SRC_C0;
            end
            (tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V1_IN): begin
                o_job.n_emit     = 3'd6;
                o_job.cut_in[0]  = 2'd1;
                o_job.cut_out[0] = 2'd2;
                o_job.cut_in[1]  = 2'd0;
                o_job.cut_out[1] = 2'd2;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V0;
                o_job.src[3] = tpc_pkg::SRC_V0;
                o_job.src[4] = tpc_pkg::SRC_V1;
                o_job.src[5] = tpc_pkg::SRC_C0;
            end
            tpc_pkg::PAT_V2_IN: begin
                o_job.cut_in[0]  = 2'd2;
                o_job.cut_out[0] = 2'd0;
                o_job.cut_in[1]  = 2'd2;
                o_job.cut_out[1] = 2'd1;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V2;
            end
            tpc_pkg::PAT_V1_IN: begin
                o_job.cut_in[0]  = 2'd1;
                o_job.cut_out[0] = 2'd2;
                o_job.cut_in[1]  = 2'd1;
                o_job.cut_out[1] = 2'd0;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V1;
            end
            tpc_pkg::PAT_V0_IN: begin
                o_job.cut_in[0]  = 2'd0;
                o_job.cut_out[0] = 2'd1;
                o_job.cut_in[1]  = 2'd0;
                o_job.cut_out[1] = 2'd2;
                o_job.src[0] = tpc_pkg::SRC_C0;
                o_job.src[1] = tpc_pkg::SRC_C1;
                o_job.src[2] = tpc_pkg::SRC_V0;
            end
            default: begin
                o_job.do_cut = 1'b0;
            end
        endcase
    end

    // fully outside triangles produce no job
    assign o_job_push = w_accept && (r_slot == 2'd2) && (w_pat != 3'b000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 2'd0;
        end else if (w_accept) begin
            r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_slot == 2'd0) begin
            r_v0 <= w_v2;
        end
        if (w_accept && r_slot == 2'd1) begin
            r_v1 <= w_v2;
        end
    end

endmodule

### rtl/core/tpc_job_queue.sv
`timescale 1ns / 1ps
module tpc_job_queue #(
    parameter int DEPTH = tpc_pkg::JobDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tpc_pkg::t_job o_job
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    tpc_pkg::t_job r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/core/tpc_back.sv
`timescale 1ns / 1ps
module tpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  tpc_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output tpc_pkg::t_out_word o_vtx
);

    localparam logic [30:0] TOne = 31'(64'd1 << tpc_pkg::TBits);
    localparam logic [4:0]  LastStep = 5'(tpc_pkg::DivSteps - 1);
    localparam logic signed [63:0] RndHalf = 64'sd1 <<< (tpc_pkg::TBits - 1);

    tpc_pkg::t_back_state r_state;
    tpc_pkg::t_back_state n_state;

    logic               r_cut;
    tpc_pkg::t_vec      r_va;
    tpc_pkg::t_vec      r_vb;
    logic [34:0]        r_den;
    logic [35:0]        r_rem;
    logic [31:0]        r_q;
    logic [4:0]         r_step;
    logic [30:0]        r_t;
    logic [3:0]         r_k;
    logic signed [63:0] r_prod;
    tpc_pkg::t_vec      r_cres [2];
    logic [2:0]         r_e;
    logic               r_out_valid;
    tpc_pkg::t_out_word r_out;

    logic               w_slot_free;
    logic               w_last;
    logic               w_out_load;
    logic [3:0]         w_ax;

    logic signed [34:0] w_ca, w_cb, w_wa, w_wb, w_n, w_d;
    logic [34:0]        w_num, w_dmag;
    logic [35:0]        w_sh;
    logic               w_ge;
    logic [32:0]        w_qp;
    logic [31:0]        w_qr;
    logic [30:0]        w_tnext;
    logic signed [32:0] w_diff;
    logic signed [63:0] w_rs;
    logic signed [63:0] w_sum;
    logic [31:0]        w_sat;
    logic [31:0]        w_cax;
    logic [31:0]        w_wfix;
    tpc_pkg::t_vec      w_src_vec;

    assign w_ax        = {2'b00, i_job.axis};
    assign w_slot_free = !r_out_valid || i_pop;
    assign w_last      = (r_e == i_job.n_emit - 3'd1);

    // cut setup: n = wB - cB, d = n + cA - wA
    always_comb begin
        w_ca = $signed({{3{r_va[w_ax][31]}}, r_va[w_ax]});
        w_cb = $signed({{3{r_vb[w_ax][31]}}, r_vb[w_ax]});
        w_wa = $signed({{3{r_va[tpc_pkg::ATTR_W][31]}}, r_va[tpc_pkg::ATTR_W]});
        w_wb = $signed({{3{r_vb[tpc_pkg::ATTR_W][31]}}, r_vb[tpc_pkg::ATTR_W]});
        if (!i_job.pos) begin
            w_wa = -w_wa;
            w_wb = -w_wb;
        end
        w_n    = w_wb - w_cb;
        w_d    = w_n + w_ca - w_wa;
        w_num  = w_n[34] ? 35'(-w_n) : 35'(w_n);
        w_dmag = w_d[34] ? 35'(-w_d) : 35'(w_d);
    end

    always_comb begin
        w_sh = {r_rem[34:0], 1'b0};
        w_ge = (w_sh >= {1'b0, r_den});
        w_qp = {1'b0, r_q} + 33'd1;
        w_qr = w_qp[32:1];
        if (r_den == '0) begin
            w_tnext = '0;
        end else if (w_qr > {1'b0, TOne}) begin
            w_tnext = TOne;
        end else begin
            w_tnext = w_qr[30:0];
        end
    end

    always_comb begin
        w_diff = $signed({r_va[r_k][31], r_va[r_k]}) - $signed({r_vb[r_k][31], r_vb[r_k]});
        w_rs   = (r_prod + RndHalf) >>> tpc_pkg::TBits;
        w_sum  = $signed({{32{r_vb[r_k][31]}}, r_vb[r_k]}) + w_rs;
        if (w_sum > 64'sd2147483647) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (w_sum < -64'sd2147483648) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
        w_cax = r_cres[r_cut][w_ax];
        if (i_job.pos) begin
            w_wfix = w_cax;
        end else if (w_cax == 32'h8000_0000) begin
            w_wfix = 32'h7FFF_FFFF;
        end else begin
            w_wfix = -w_cax;
        end
    end

    always_comb begin
        case (tpc_pkg::t_src'(i_job.src[r_e]))
            tpc_pkg::SRC_V0: w_src_vec = i_job.vtx[0];
            tpc_pkg::SRC_V1: w_src_vec = i_job.vtx[1];
            tpc_pkg::SRC_V2: w_src_vec = i_job.vtx[2];
            tpc_pkg::SRC_C0: w_src_vec = r_cres[0];
            tpc_pkg::SRC_C1: w_src_vec = r_cres[1];
            default:         w_src_vec = i_job.vtx[0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tpc_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.do_cut ? tpc_pkg::B_LOAD : tpc_pkg::B_EMIT;
                end
            end
            tpc_pkg::B_LOAD:  n_state = tpc_pkg::B_SETUP;
            tpc_pkg::B_SETUP: n_state = tpc_pkg::B_PRE1;
            tpc_pkg::B_PRE1:  n_state = tpc_pkg::B_PRE2;
            tpc_pkg::B_PRE2:  n_state = tpc_pkg::B_DIV;
            tpc_pkg::B_DIV: begin
                if (r_step == LastStep) begin
                    n_state = tpc_pkg::B_ROUND;
                end
            end
            tpc_pkg::B_ROUND: n_state = tpc_pkg::B_MUL;
            tpc_pkg::B_MUL:   n_state = tpc_pkg::B_ACC;
            tpc_pkg::B_ACC: begin
                n_state = (r_k == 4'd8) ? tpc_pkg::B_WFIX : tpc_pkg::B_MUL;
            end
            tpc_pkg::B_WFIX: begin
                n_state = r_cut ? tpc_pkg::B_EMIT : tpc_pkg::B_LOAD;
            end
            tpc_pkg::B_EMIT: begin
                if (w_slot_free && w_last) begin
                    n_state = tpc_pkg::B_IDLE;
                end
            end
            default: n_state = tpc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        w_out_load = 1'b0;
        o_job_pop  = 1'b0;
        case (r_state)
            tpc_pkg::B_EMIT: begin
                w_out_load = w_slot_free;
                o_job_pop  = w_slot_free && w_last;
            end
            default: begin
                w_out_load = 1'b0;
                o_job_pop  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpc_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tpc_pkg::B_IDLE: begin
                r_cut <= 1'b0;
                r_e   <= 3'd0;
            end
            tpc_pkg::B_LOAD: begin
                r_va <= i_job.vtx[i_job.cut_in[r_cut]];
                r_vb <= i_job.vtx[i_job.cut_out[r_cut]];
            end
            tpc_pkg::B_SETUP: begin
                r_rem <= {1'b0, w_num};
                r_den <= w_dmag;
                r_q   <= '0;
            end
            tpc_pkg::B_PRE1: begin
                if (r_rem >= {1'b0, r_den}) begin
                    r_q   <= 32'd1;
                    r_rem <= r_rem - {1'b0, r_den};
                end
                r_step <= '0;
            end
            tpc_pkg::B_PRE2: begin
                if (r_rem >= {1'b0, r_den}) begin
                    r_rem <= '0;
                end
            end
            tpc_pkg::B_DIV: begin
                r_rem  <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q    <= {r_q[30:0], w_ge};
                r_step <= r_step + 5'd1;
            end
            tpc_pkg::B_ROUND: begin
                r_t <= w_tnext;
                r_k <= 4'd0;
            end
            tpc_pkg::B_MUL: begin
                r_prod <= w_diff * $signed({1'b0, r_t});
            end
            tpc_pkg::B_ACC: begin
                r_cres[r_cut][r_k] <= w_sat;
                r_k <= (r_k == 4'd2) ? 4'd4 : r_k + 4'd1;
            end
            tpc_pkg::B_WFIX: begin
                r_cres[r_cut][tpc_pkg::ATTR_W] <= w_wfix;
                r_cut <= 1'b1;
            end
            tpc_pkg::B_EMIT: begin
                if (w_slot_free) begin
                    r_e <= r_e + 3'd1;
                end
            end
            default: begin
                r_e <= r_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= tpc_pkg::to_out(w_src_vec, w_last);
        end
    end

    assign o_empty = !r_out_valid;
    assign o_vtx   = r_out;

    a_emit_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpc_pkg::B_EMIT |-> i_job_valid)
        else $error("emitting without a job");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpc_pkg::B_EMIT |-> r_e < i_job.n_emit)
        else $error("emit index past word count");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpc_pkg::B_MUL |-> r_t <= TOne)
        else $error("ratio above one");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_out_valid && r_out.run_last))
        else $error("job retired without last word");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

    typedef longint t_lv [9];

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    tpc_pkg::t_in_word  i_vtx;
    logic               empty;
    logic               pop;
    tpc_pkg::t_out_word o_vtx;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    triangle_plane_clipper dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_vtx  (i_vtx),
        .empty  (empty),
        .pop    (pop),
        .o_vtx  (o_vtx),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // predictor state
    logic [1:0]         plane_axis;
    logic               plane_pos;
    tpc_pkg::t_in_word  held0;
    tpc_pkg::t_in_word  held1;
    int                 held_cnt;
    tpc_pkg::t_out_word clip_words [$];

    int  errors;
    bit  no_idle;
    int  pop_stall;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_lv to_lv(tpc_pkg::t_in_word w);
        t_lv v;
        v[0] = longint'(w.pos_x); v[1] = longint'(w.pos_y); v[2] = longint'(w.pos_z);
        v[3] = longint'(w.pos_w); v[4] = longint'(w.col_r); v[5] = longint'(w.col_g);
        v[6] = longint'(w.col_b); v[7] = longint'(w.tex_u); v[8] = longint'(w.tex_v);
        return v;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic bit beyond_plane(t_lv v);
        if (plane_axis == tpc_pkg::AXIS_NONE) return 1'b0;
        return plane_pos ? (v[plane_axis] > v[3]) : (v[plane_axis] < -v[3]);
    endfunction

    // a inside, b outside
    function automatic t_lv cut_point(t_lv a, t_lv b);
        t_lv r;
        longint wa, wb, n, d, t, p;
        longint unsigned num, den, q, rem;
        wa = plane_pos ? a[3] : -a[3];
        wb = plane_pos ? b[3] : -b[3];
        n = wb - b[plane_axis];
        d = n + a[plane_axis] - wa;
        num = (n < 0) ? -n : n;
        den = (d < 0) ? -d : d;
        q = 0;
        rem = num;
        if (den == 0) begin
            t = 0;
        end else begin
            if (rem >= den) begin q = 1; rem -= den; end
            if (rem >= den) rem = 0;
            for (int i = 0; i < tpc_pkg::TBits + 1; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin q |= 1; rem -= den; end
            end
            q = (q + 1) >> 1;
            if (q > (64'd1 << tpc_pkg::TBits)) q = 64'd1 << tpc_pkg::TBits;
            t = q;
        end
        for (int k = 0; k < tpc_pkg::NumAttr; k++) begin
            p = (a[k] - b[k]) * t;
            r[k] = sat32(b[k] + ((p + (64'sd1 <<< (tpc_pkg::TBits - 1))) >>> tpc_pkg::TBits));
        end
        r[3] = sat32(plane_pos ? r[plane_axis] : -r[plane_axis]);
        return r;
    endfunction

    function automatic void expect_vertex(t_lv v, bit last);
        tpc_pkg::t_out_word w;
        w.out_x = v[0][31:0]; w.out_y = v[1][31:0]; w.out_z = v[2][31:0];
        w.out_w = v[3][31:0]; w.out_r = v[4][31:0]; w.out_g = v[5][31:0];
        w.out_b = v[6][31:0]; w.out_u = v[7][31:0]; w.out_v = v[8][31:0];
        w.run_last = last;
        clip_words.insert(clip_words.size(), w);
    endfunction

    function automatic void predict_quad(t_lv pi, t_lv pj, t_lv po);
        t_lv ci, cj;
        ci = cut_point(pi, po);
        cj = cut_point(pj, po);
        expect_vertex(cj, 1'b0); expect_vertex(ci, 1'b0); expect_vertex(pi, 1'b0);
        expect_vertex(pi, 1'b0); expect_vertex(pj, 1'b0); expect_vertex(cj, 1'b1);
    endfunction

    function automatic void predict_tri(t_lv pk, t_lv pa, t_lv pb);
        expect_vertex(cut_point(pk, pa), 1'b0);
        expect_vertex(cut_point(pk, pb), 1'b0);
        expect_vertex(pk, 1'b1);
    endfunction

    function automatic void predict_clip(tpc_pkg::t_in_word w);
        t_lv v0, v1, v2;
        logic [2:0] pat;
        if (held_cnt < 2) begin
            if (held_cnt == 0) held0 = w; else held1 = w;
            held_cnt++;
            return;
        end
        held_cnt = 0;
        v0 = to_lv(held0);
        v1 = to_lv(held1);
        v2 = to_lv(w);
        pat = (beyond_plane(v0) ? 3'b000 : tpc_pkg::PAT_V0_IN) |
              (beyond_plane(v1) ? 3'b000 : tpc_pkg::PAT_V1_IN) |
              (beyond_plane(v2) ? 3'b000 : tpc_pkg::PAT_V2_IN);
        case (pat)
            tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V1_IN | tpc_pkg::PAT_V2_IN: begin
                expect_vertex(v0, 1'b0); expect_vertex(v1, 1'b0); expect_vertex(v2, 1'b1);
            end
            tpc_pkg::PAT_V1_IN | tpc_pkg::PAT_V2_IN: predict_quad(v1, v2, v0);
            tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V2_IN: predict_quad(v2, v0, v1);
            tpc_pkg::PAT_V0_IN | tpc_pkg::PAT_V1_IN: predict_quad(v0, v1, v2);
            tpc_pkg::PAT_V2_IN: predict_tri(v2, v0, v1);
            tpc_pkg::PAT_V1_IN: predict_tri(v1, v2, v0);
            tpc_pkg::PAT_V0_IN: predict_tri(v0, v1, v2);
            default: ;
        endcase
    endfunction

    task automatic chk(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        tpc_pkg::t_out_word e;
        if (i_rst_n && pop && !empty) begin
            if (clip_words.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, o_vtx);
                errors++;
            end else begin
                e = clip_words.pop_front();
                chk("x", e.out_x, o_vtx.out_x);
                chk("y", e.out_y, o_vtx.out_y);
                chk("z", e.out_z, o_vtx.out_z);
                chk("w", e.out_w, o_vtx.out_w);
                chk("r", e.out_r, o_vtx.out_r);
                chk("g", e.out_g, o_vtx.out_g);
                chk("b", e.out_b, o_vtx.out_b);
                chk("u", e.out_u, o_vtx.out_u);
                chk("v", e.out_v, o_vtx.out_v);
                chk("run_last", {31'd0, e.run_last}, {31'd0, o_vtx.run_last});
            end
        end
    end

    always @(negedge i_clk) begin
        if (no_idle || !i_rst_n) begin
            pop = 1'b1;
        end else if (pop_stall > 0) begin
            pop_stall--;
            pop = 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            pop_stall = $urandom_range(0, 2);
            pop = 1'b0;
        end else begin
            pop = 1'b1;
        end
    end

    task automatic send_vertex(tpc_pkg::t_in_word w);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_vtx = w;
        push = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        predict_clip(w);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        paddr = {idx, 2'b00};
        pwdata = val;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (idx == tpc_pkg::REG_AXIS) plane_axis = val[1:0];
        else plane_pos = val[0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain;
        wait (clip_words.size() == 0);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic set_plane(logic [1:0] ax, logic ps);
        drain();
        write_reg(tpc_pkg::REG_AXIS, {30'd0, ax});
        write_reg(tpc_pkg::REG_POS, {31'd0, ps});
    endtask

    function automatic tpc_pkg::t_in_word make_vtx(int x, int w);
        tpc_pkg::t_in_word v;
        v.pos_x = x; v.pos_y = $urandom; v.pos_z = $urandom; v.pos_w = w;
        v.col_r = $urandom; v.col_g = $urandom; v.col_b = $urandom;
        v.tex_u = $urandom; v.tex_v = $urandom;
        return v;
    endfunction

    // coordinate on the active axis placed around the plane
    function automatic tpc_pkg::t_in_word rand_vtx;
        tpc_pkg::t_in_word v;
        longint w, c;
        v = make_vtx($urandom, $urandom);
        if ($urandom_range(0, 5) == 0) return v;
        w = longint'($urandom_range(1, 1 << 22));
        if ($urandom_range(0, 9) == 0) w = -w;
        c = (w * (longint'($urandom_range(0, 400)) - 200)) / 100;
        v.pos_w = 32'(w);
        case ($urandom_range(0, 2))
            0: v.pos_x = 32'(c);
            1: v.pos_y = 32'(c);
            default: v.pos_z = 32'(c);
        endcase
        if (plane_axis == 2'd0) v.pos_x = 32'(c);
        else if (plane_axis == 2'd1) v.pos_y = 32'(c);
        else if (plane_axis == 2'd2) v.pos_z = 32'(c);
        return v;
    endfunction

    task automatic test_patterns;
        set_plane(2'd0, 1'b1);
        for (int p = 0; p < 8; p++)
            for (int k = 0; k < 3; k++)
                send_vertex(make_vtx(p[2 - k] ? 0 : 32'h20000, 32'h10000));
    endtask

    task automatic test_extremes;
        tpc_pkg::t_in_word hi, lo;
        hi = {9{32'h7fffffff}};
        lo = {9{32'h80000000}};
        set_plane(2'd0, 1'b0);
        send_vertex(lo); send_vertex(hi); send_vertex(lo);
        set_plane(tpc_pkg::AXIS_NONE, 1'b1);
        send_vertex(hi); send_vertex(lo); send_vertex(hi);
    endtask

    task automatic test_mid_triangle_config;
        set_plane(2'd1, 1'b1);
        send_vertex(rand_vtx());
        drain();
        write_reg(tpc_pkg::REG_AXIS, 32'd2);
        write_reg(tpc_pkg::REG_POS, 32'd0);
        send_vertex(rand_vtx());
        send_vertex(rand_vtx());
    endtask

    task automatic test_random_planes;
        for (int s = 0; s < 8; s++) begin
            set_plane(2'(s % 4), 1'(s / 4));
            repeat (33) send_vertex(rand_vtx());
        end
    endtask

    task automatic test_no_idle;
        set_plane(2'd2, 1'b1);
        drain();
        no_idle = 1'b1;
        repeat (15) send_vertex(rand_vtx());
    endtask

    initial begin
        errors = 0;
        no_idle = 1'b0;
        pop_stall = 0;
        held_cnt = 0;
        plane_axis = 2'd0;
        plane_pos = 1'b1;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b1;
        i_vtx = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_patterns();
        test_extremes();
        test_mid_triangle_config();
        test_random_planes();
        test_no_idle();

        wait (clip_words.size() == 0);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/tpc_pkg.sv
rtl/core/tpc_front.sv
rtl/core/tpc_job_queue.sv
rtl/core/tpc_back.sv
rtl/core/triangle_plane_clipper.sv
tb/tb.sv
